// ----- rtl/chi_pkg.sv -----
// Package for the coupler host interface: codes, widths and constants.
// Depends on nothing; every rtl file uses it by scoped names.
`timescale 1ns / 1ps
package chi_pkg;
  localparam int AddrBits = 16;
  localparam int MemWords = 1 << AddrBits;

  localparam logic [1:0] KindFunc = 2'd0;
  localparam logic [1:0] KindIo   = 2'd1;
  localparam logic [1:0] KindTick = 2'd2;

  localparam logic [8:0] FnRdAddrHi = 9'o000;
  localparam logic [8:0] FnRdAddrLo = 9'o001;
  localparam logic [8:0] FnDataA    = 9'o003;
  localparam logic [8:0] FnRdStatus = 9'o004;
  localparam logic [8:0] FnRdCoupl  = 9'o005;
  localparam logic [8:0] FnRdOrder  = 9'o006;
  localparam logic [8:0] FnDump     = 9'o007;
  localparam logic [8:0] FnWrAddrHi = 9'o010;
  localparam logic [8:0] FnWrAddrLo = 9'o011;
  localparam logic [8:0] FnDataB    = 9'o014;
  localparam logic [8:0] FnLoad     = 9'o015;
  localparam logic [8:0] FnWrStatus = 9'o016;
  localparam logic [8:0] FnStart    = 9'o040;
  localparam logic [8:0] FnMaster   = 9'o200;
  localparam logic [8:0] FnClear    = 9'o400;
  localparam logic [8:0] FnNothing  = 9'h1FF;

  localparam logic [1:0] StNotInit = 2'd0;
  localparam logic [1:0] StRunning = 2'd1;
  localparam logic [1:0] StReset   = 2'd2;

  localparam logic [1:0] FsDeclined  = 2'd0;
  localparam logic [1:0] FsAccepted  = 2'd1;
  localparam logic [1:0] FsProcessed = 2'd2;

  localparam logic [2:0] EvNone    = 3'd0;
  localparam logic [2:0] EvService = 3'd1;
  localparam logic [2:0] EvDataHi  = 3'd2;
  localparam logic [2:0] EvDataLo  = 3'd3;
  localparam logic [2:0] EvRetry   = 3'd4;
  localparam logic [2:0] EvInit    = 3'd5;
  localparam logic [2:0] EvResetSs = 3'd6;
  localparam logic [2:0] EvStartRn = 3'd7;

  localparam logic [15:0] SumImageA = 16'hAC79;
  localparam logic [15:0] SumImageB = 16'h4A2B;
  localparam logic [15:0] SumImageC = 16'h8610;
  localparam logic [15:0] SumImageD = 16'hEC98;
  localparam logic [15:0] PatchWord = 16'd1024;
  localparam logic [AddrBits-1:0] PatchAddr = AddrBits'(9'h1FF);

  localparam logic [19:0] TickMax      = 20'hFFFFF;
  localparam logic [19:0] IdleReset    = 20'd100000;

  typedef struct packed {
    logic                wr;
    logic [AddrBits-1:0] addr;
    logic [15:0]         wdata;
  } mem_req_t;
endpackage

// ----- rtl/chi_ram.sv -----
// Program store: single port synchronous RAM with a registered read.
// Depends on chi_pkg for the request type and depth.
`timescale 1ns / 1ps
module chi_ram (
  input  logic              clk_i,
  input  logic              clear_i,
  input  chi_pkg::mem_req_t req_i,
  output logic [15:0]       rdata_o
);
  logic [15:0] mem_q [chi_pkg::MemWords];

  // A write during the clearing sweep stores zero.
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= clear_i ? 16'd0 : req_i.wdata;
    end
    rdata_o <= mem_q[req_i.addr];
  end
endmodule

// ----- rtl/coupler_host_interface.sv -----
// Coupler host interface top level: control sequencer around the program store.
// Depends on chi_pkg and chi_ram.
// The block takes one item at a time: a new item is accepted only after the result of the
// last has been taken. A start reads sixteen words through the single RAM port one a cycle.
// Reset clears the registers at once; a sweep then zeroes the program store while
// in_ready_o is low.
`timescale 1ns / 1ps
module coupler_host_interface (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [11:0] func_code_i,
  input  logic [11:0] chan_data_i,
  input  logic        chan_full_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  func_status_o,
  output logic [11:0] read_data_o,
  output logic        read_valid_o,
  output logic        data_taken_o,
  output logic [2:0]  event_res_o,
  output logic [10:0] coupler_flags_o,
  output logic        hcp_running_o
);
  localparam int AW = chi_pkg::AddrBits;

  typedef enum logic [2:0] {SClear, SIdle, SExec, SSum, SOut} state_e;

  state_e      state_q;
  logic [AW:0] clr_q;
  logic [19:0] interval_q, ticks_q;
  logic [10:0] coupler_q;
  logic [11:0] status_q, order_q;
  logic [15:0] ptr_q;
  logic [7:0]  hi_q, byte_q;
  logic        half_q;
  logic [1:0]  prog_q;
  logic [8:0]  fn_q;
  logic [1:0]  kind_q;
  logic [8:0]  fc_q;
  logic [11:0] data_q;
  logic        full_q;
  logic [4:0]  cnt_q;
  logic [15:0] sum_q;

  chi_pkg::mem_req_t req;
  logic [15:0]       rdata;

  chi_ram u_ram (
    .clk_i, .clear_i(state_q == SClear), .req_i(req), .rdata_o(rdata)
  );

  // The configuration register only feeds comparisons, so a write is always taken.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign hcp_running_o = (prog_q == chi_pkg::StRunning);

  // Store index for the current item: pointer, or first words for a start.
  logic start_item;
  assign start_item = (kind_i == chi_pkg::KindFunc) && (func_code_i[8:0] == chi_pkg::FnStart);

  // Request mux: clearing sweep, pointer read while idle, start summing, a load or patch write.
  logic        ex_wr;
  logic [15:0] ex_wdata;
  logic [AW-1:0] ex_addr;
  always_comb begin
    req = '0;
    if (state_q == SClear) begin
      req.wr = 1'b1;
      req.addr = clr_q[AW-1:0];
    end else if (state_q == SIdle) begin
      req.addr = start_item ? '0 : ptr_q[AW-1:0];
    end else if (state_q == SSum) begin
      req.addr = AW'(cnt_q[3:0] + 5'd1);
    end else if (state_q == SExec) begin
      req.wr = ex_wr; req.addr = ex_addr; req.wdata = ex_wdata;
    end
  end

  // Item evaluation, done in SExec. A start compares the finished sum in sum_q.
  logic [10:0] cp_d;
  logic [11:0] st_d, ord_d;
  logic [15:0] ptr_d, sum_full;
  logic [7:0]  hi_d, byte_d;
  logic        half_d;
  logic [1:0]  prog_d, fs_d;
  logic [8:0]  fn_d;
  logic [19:0] tk_d;
  logic [11:0] rd_d;
  logic        rv_d, tk_o_d;
  logic [2:0]  ev_d;

  assign sum_full = sum_q + rdata;

  always_comb begin
    cp_d = coupler_q; st_d = status_q; ord_d = order_q; ptr_d = ptr_q;
    hi_d = hi_q; byte_d = byte_q; half_d = half_q; prog_d = prog_q;
    fn_d = fn_q; tk_d = ticks_q; fs_d = chi_pkg::FsDeclined;
    rd_d = '0; rv_d = 1'b0; tk_o_d = 1'b0; ev_d = chi_pkg::EvNone;
    ex_wr = 1'b0; ex_wdata = '0; ex_addr = ptr_q[AW-1:0];
    case (kind_q)
      chi_pkg::KindFunc: begin
        fs_d = chi_pkg::FsAccepted;
        fn_d = fc_q;
        case (fc_q)
          chi_pkg::FnRdCoupl: begin
            if (hcp_running_o && ticks_q > interval_q) begin
              st_d = 12'd1; cp_d[2] = 1'b1; tk_d = '0;
            end
          end
          chi_pkg::FnDataA, chi_pkg::FnDataB: begin
            fs_d = chi_pkg::FsDeclined; fn_d = chi_pkg::FnNothing;
          end
          chi_pkg::FnRdAddrHi, chi_pkg::FnRdAddrLo, chi_pkg::FnRdStatus,
          chi_pkg::FnRdOrder, chi_pkg::FnDump, chi_pkg::FnWrAddrHi,
          chi_pkg::FnWrAddrLo, chi_pkg::FnLoad: ;
          chi_pkg::FnWrStatus: begin
            st_d = 12'd1; cp_d[2] = 1'b1; tk_d = '0;
          end
          chi_pkg::FnMaster: begin
            if (hcp_running_o) begin
              ev_d = chi_pkg::EvResetSs; prog_d = chi_pkg::StReset;
            end
            cp_d = '0; half_d = 1'b0;
          end
          chi_pkg::FnClear: cp_d = coupler_q & 11'h004;
          chi_pkg::FnStart: begin
            fs_d = chi_pkg::FsProcessed; fn_d = fn_q;
            if (sum_q == chi_pkg::SumImageA) begin
              st_d = 12'd1; cp_d[2] = 1'b1; tk_d = '0;
            end else if (sum_q == chi_pkg::SumImageB) begin
              ex_wr = 1'b1; ex_addr = chi_pkg::PatchAddr; ex_wdata = chi_pkg::PatchWord;
              st_d = 12'o010; cp_d[2] = 1'b1; tk_d = '0;
            end else if (sum_q == chi_pkg::SumImageC || sum_q == chi_pkg::SumImageD) begin
              if (hcp_running_o) ev_d = chi_pkg::EvStartRn;
              else begin
                prog_d = chi_pkg::StRunning; ev_d = chi_pkg::EvInit;
              end
            end
          end
          default: begin
            fs_d = chi_pkg::FsDeclined; fn_d = fn_q;
          end
        endcase
      end
      chi_pkg::KindIo: begin
        case (fn_q)
          chi_pkg::FnRdStatus: begin
            rd_d = status_q; rv_d = 1'b1; st_d = '0; cp_d[2] = 1'b0;
          end
          chi_pkg::FnRdCoupl: begin
            rd_d = {1'b0, coupler_q}; rv_d = 1'b1; cp_d[9] = 1'b1;
          end
          chi_pkg::FnRdOrder: begin
            rd_d = order_q; rv_d = 1'b1;
          end
          chi_pkg::FnRdAddrHi: begin
            rd_d = {4'd0, ptr_q[15:8]}; rv_d = 1'b1;
          end
          chi_pkg::FnRdAddrLo: begin
            rd_d = {4'd0, ptr_q[7:0]}; rv_d = 1'b1; cp_d[3] = 1'b1;
          end
          chi_pkg::FnWrStatus: begin
            if (full_q) begin
              ord_d = data_q; tk_o_d = 1'b1;
              case (data_q[11:9])
                3'd1: ev_d = chi_pkg::EvService;
                3'd2: ev_d = chi_pkg::EvDataHi;
                3'd3: ev_d = chi_pkg::EvDataLo;
                3'd5: ev_d = chi_pkg::EvRetry;
                default: ev_d = chi_pkg::EvNone;
              endcase
            end
          end
          chi_pkg::FnDump: begin
            if (half_q) begin
              half_d = 1'b0; rd_d = {4'd0, rdata[7:0]}; ptr_d = ptr_q + 16'd1;
            end else begin
              half_d = 1'b1; rd_d = {4'd0, rdata[15:8]};
            end
            rv_d = 1'b1; cp_d[5] = 1'b1;
          end
          chi_pkg::FnWrAddrHi: begin
            if (full_q) begin
              hi_d = data_q[7:0]; tk_o_d = 1'b1;
            end
          end
          chi_pkg::FnWrAddrLo: begin
            if (full_q) begin
              ptr_d = {hi_q, data_q[7:0]}; tk_o_d = 1'b1;
            end
            cp_d[3] = 1'b1;
          end
          chi_pkg::FnLoad: begin
            if (full_q) begin
              if (half_q) begin
                ex_wr = 1'b1; ex_wdata = {byte_q, data_q[7:0]};
                half_d = 1'b0; ptr_d = ptr_q + 16'd1; cp_d[5] = 1'b1;
              end else begin
                half_d = 1'b1; byte_d = data_q[7:0];
              end
              tk_o_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      chi_pkg::KindTick: begin
        if (ticks_q < chi_pkg::TickMax) tk_d = ticks_q + 20'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear; clr_q <= '0; interval_q <= chi_pkg::IdleReset;
      ticks_q <= '0; coupler_q <= '0; status_q <= '0; order_q <= '0;
      ptr_q <= '0; hi_q <= '0; byte_q <= '0; half_q <= 1'b0;
      prog_q <= chi_pkg::StNotInit; fn_q <= chi_pkg::FnNothing;
      kind_q <= '0; fc_q <= '0; data_q <= '0; full_q <= 1'b0;
      cnt_q <= '0; sum_q <= '0;
      func_status_o <= '0; read_data_o <= '0; read_valid_o <= 1'b0;
      data_taken_o <= 1'b0; event_res_o <= '0; coupler_flags_o <= '0;
    end else begin
      if (cfg_valid_i) interval_q <= cfg_data_i;
      case (state_q)
        SClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (AW+1)'(chi_pkg::MemWords - 1)) state_q <= SIdle;
        end
        SIdle: begin
          if (in_valid_i) begin
            kind_q <= kind_i; fc_q <= func_code_i[8:0];
            data_q <= chan_data_i; full_q <= chan_full_i;
            cnt_q <= '0; sum_q <= '0;
            state_q <= start_item ? SSum : SExec;
          end
        end
        SSum: begin
          // Word cnt_q arrives from the store in this cycle; the last one closes
          // the sum, and a spare pass with cnt_q at 16 comes before the update.
          if (cnt_q == 5'd15) begin
            cnt_q <= 5'd16;
            sum_q <= sum_full;
          end else if (cnt_q == 5'd16) begin
            state_q <= SExec;
          end else begin
            sum_q <= sum_full; cnt_q <= cnt_q + 5'd1;
          end
        end
        SExec: begin
          coupler_q <= cp_d; status_q <= st_d; order_q <= ord_d; ptr_q <= ptr_d;
          hi_q <= hi_d; byte_q <= byte_d; half_q <= half_d; prog_q <= prog_d;
          fn_q <= fn_d; ticks_q <= tk_d;
          func_status_o <= fs_d; read_data_o <= rd_d; read_valid_o <= rv_d;
          data_taken_o <= tk_o_d; event_res_o <= ev_d; coupler_flags_o <= cp_d;
          state_q <= SOut;
        end
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  // A waiting result beat holds its payload until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(coupler_flags_o) && $stable(event_res_o) && $stable(func_status_o));

  // Only one item is ever in flight, so input and output never overlap.
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o));

  // The function reply and the program state stay within their defined codes.
  a_fs_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> func_status_o <= chi_pkg::FsProcessed);
  a_prog_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q <= chi_pkg::StReset);

  // Read data is zero in every result beat with read_valid_o low.
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_data_o == 12'd0);
endmodule

// ----- test/tb.sv -----
// Testbench for coupler_host_interface: directed table, then random command sequences.
// Depends on chi_pkg and the rtl; each result is checked by a predictor or a fixed reply.
`timescale 1ns / 1ps
module tb;
  // Codes and constants taken from the package.
  localparam int          MemWords    = chi_pkg::MemWords;
  localparam logic [1:0]  KindFunc    = chi_pkg::KindFunc;
  localparam logic [1:0]  KindIo      = chi_pkg::KindIo;
  localparam logic [1:0]  KindTick    = chi_pkg::KindTick;
  localparam logic [8:0]  FnRdAddrHi  = chi_pkg::FnRdAddrHi;
  localparam logic [8:0]  FnRdAddrLo  = chi_pkg::FnRdAddrLo;
  localparam logic [8:0]  FnDataA     = chi_pkg::FnDataA;
  localparam logic [8:0]  FnRdStatus  = chi_pkg::FnRdStatus;
  localparam logic [8:0]  FnRdCoupl   = chi_pkg::FnRdCoupl;
  localparam logic [8:0]  FnRdOrder   = chi_pkg::FnRdOrder;
  localparam logic [8:0]  FnDump      = chi_pkg::FnDump;
  localparam logic [8:0]  FnWrAddrHi  = chi_pkg::FnWrAddrHi;
  localparam logic [8:0]  FnWrAddrLo  = chi_pkg::FnWrAddrLo;
  localparam logic [8:0]  FnDataB     = chi_pkg::FnDataB;
  localparam logic [8:0]  FnLoad      = chi_pkg::FnLoad;
  localparam logic [8:0]  FnWrStatus  = chi_pkg::FnWrStatus;
  localparam logic [8:0]  FnStart     = chi_pkg::FnStart;
  localparam logic [8:0]  FnMaster    = chi_pkg::FnMaster;
  localparam logic [8:0]  FnClear     = chi_pkg::FnClear;
  localparam logic [8:0]  FnNothing   = chi_pkg::FnNothing;
  localparam logic [1:0]  StNotInit   = chi_pkg::StNotInit;
  localparam logic [1:0]  StRunning   = chi_pkg::StRunning;
  localparam logic [1:0]  StReset     = chi_pkg::StReset;
  localparam logic [1:0]  FsDeclined  = chi_pkg::FsDeclined;
  localparam logic [1:0]  FsAccepted  = chi_pkg::FsAccepted;
  localparam logic [1:0]  FsProcessed = chi_pkg::FsProcessed;
  localparam logic [2:0]  EvNone      = chi_pkg::EvNone;
  localparam logic [2:0]  EvService   = chi_pkg::EvService;
  localparam logic [2:0]  EvDataHi    = chi_pkg::EvDataHi;
  localparam logic [2:0]  EvDataLo    = chi_pkg::EvDataLo;
  localparam logic [2:0]  EvRetry     = chi_pkg::EvRetry;
  localparam logic [2:0]  EvInit      = chi_pkg::EvInit;
  localparam logic [2:0]  EvResetSs   = chi_pkg::EvResetSs;
  localparam logic [2:0]  EvStartRn   = chi_pkg::EvStartRn;
  localparam logic [15:0] SumImageA   = chi_pkg::SumImageA;
  localparam logic [15:0] SumImageB   = chi_pkg::SumImageB;
  localparam logic [15:0] SumImageC   = chi_pkg::SumImageC;
  localparam logic [15:0] SumImageD   = chi_pkg::SumImageD;
  localparam logic [15:0] PatchWord   = chi_pkg::PatchWord;
  localparam logic [chi_pkg::AddrBits-1:0] PatchAddr = chi_pkg::PatchAddr;
  localparam logic [19:0] TickMax     = chi_pkg::TickMax;
  localparam logic [19:0] IdleReset   = chi_pkg::IdleReset;

  // Coupler status bits touched by the functions.
  localparam logic [10:0] FlStatusFull = 11'h004;
  localparam logic [10:0] FlAddrSeen   = 11'h008;
  localparam logic [10:0] FlMemMoved   = 11'h020;
  localparam logic [10:0] FlCouplRead  = 11'h200;
  localparam int          StallLimit   = 300000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] fc;
    logic [11:0] data;
    logic        full;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  fs;
    logic [11:0] rd;
    logic        rv;
    logic        tk;
    logic [2:0]  ev;
    logic [10:0] fl;
    logic        run;
  } reply_t;

  typedef struct packed {
    cmd_t   cmd;
    logic   given;
    reply_t reply;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [19:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = '0;
  logic [11:0] func_code_i = '0;
  logic [11:0] chan_data_i = '0;
  logic        chan_full_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  func_status_o;
  logic [11:0] read_data_o;
  logic        read_valid_o;
  logic        data_taken_o;
  logic [2:0]  event_res_o;
  logic [10:0] coupler_flags_o;
  logic        hcp_running_o;

  coupler_host_interface dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state, a shadow of the coupler's registers and program store.
  logic [19:0] idle_ticks;
  logic [10:0] flags;
  logic [11:0] status_word;
  logic [11:0] order_word;
  logic [15:0] mem_ptr;
  logic [7:0]  addr_hi;
  logic [7:0]  byte_lo;
  logic        half;
  logic [1:0]  prog_st;
  logic [8:0]  act_fn;
  logic [19:0] tick_cnt;
  logic [15:0] image_mem [0:MemWords-1];

  reply_t replies_due[$];
  int     mismatches = 0;
  int     stall_cycles = 0;
  logic   calm = 1'b0;     // When set, neither side idles.
  logic   hold_done = 1'b0;

  function automatic void post_status(logic [11:0] v);
    status_word = v;
    flags |= FlStatusFull;
    tick_cnt = '0;
  endfunction

  function automatic reply_t coupler_step(cmd_t c);
    reply_t r;
    logic [8:0]  fc;
    logic [15:0] sum;
    logic [15:0] w;
    r = '0;
    fc = c.fc[8:0];
    sum = '0;
    if (c.kind == KindFunc) begin
      case (fc)
        FnRdCoupl: begin
          if (prog_st == StRunning && tick_cnt > idle_ticks) post_status(12'd1);
          r.fs = FsAccepted;
          act_fn = fc;
        end
        FnDataA, FnDataB: act_fn = FnNothing;
        FnRdAddrHi, FnRdAddrLo, FnRdStatus, FnRdOrder, FnDump,
        FnWrAddrHi, FnWrAddrLo, FnLoad: begin
          r.fs = FsAccepted;
          act_fn = fc;
        end
        FnWrStatus: begin
          post_status(12'd1);
          r.fs = FsAccepted;
          act_fn = fc;
        end
        FnMaster: begin
          if (prog_st == StRunning) begin
            r.ev = EvResetSs;
            prog_st = StReset;
          end
          flags = '0;
          half = 1'b0;
          r.fs = FsAccepted;
          act_fn = fc;
        end
        FnClear: begin
          flags &= FlStatusFull;
          r.fs = FsAccepted;
          act_fn = fc;
        end
        FnStart: begin
          for (int i = 0; i < 16; i++) sum += image_mem[i];
          if (sum == SumImageA) begin
            post_status(12'd1);
          end else if (sum == SumImageB) begin
            image_mem[PatchAddr] = PatchWord;
            post_status(12'o010);
          end else if (sum == SumImageC || sum == SumImageD) begin
            if (prog_st == StRunning) begin
              r.ev = EvStartRn;
            end else begin
              prog_st = StRunning;
              r.ev = EvInit;
            end
          end
          r.fs = FsProcessed;
        end
        default: ;
      endcase
    end else if (c.kind == KindIo) begin
      case (act_fn)
        FnRdStatus: begin
          r.rd = status_word;
          r.rv = 1'b1;
          status_word = '0;
          flags &= ~FlStatusFull;
        end
        FnRdCoupl: begin
          r.rd = {1'b0, flags};
          r.rv = 1'b1;
          flags |= FlCouplRead;
        end
        FnRdOrder: begin
          r.rd = order_word;
          r.rv = 1'b1;
        end
        FnRdAddrHi: begin
          r.rd = {4'h0, mem_ptr[15:8]};
          r.rv = 1'b1;
        end
        FnRdAddrLo: begin
          r.rd = {4'h0, mem_ptr[7:0]};
          r.rv = 1'b1;
          flags |= FlAddrSeen;
        end
        FnWrStatus: if (c.full) begin
          order_word = c.data;
          r.tk = 1'b1;
          case (c.data[11:9])
            3'd1: r.ev = EvService;
            3'd2: r.ev = EvDataHi;
            3'd3: r.ev = EvDataLo;
            3'd5: r.ev = EvRetry;
            default: ;
          endcase
        end
        FnDump: begin
          w = image_mem[mem_ptr];
          if (half) begin
            half = 1'b0;
            r.rd = {4'h0, w[7:0]};
            mem_ptr++;
          end else begin
            half = 1'b1;
            r.rd = {4'h0, w[15:8]};
          end
          r.rv = 1'b1;
          flags |= FlMemMoved;
        end
        FnWrAddrHi: if (c.full) begin
          addr_hi = c.data[7:0];
          r.tk = 1'b1;
        end
        FnWrAddrLo: begin
          if (c.full) begin
            mem_ptr = {addr_hi, c.data[7:0]};
            r.tk = 1'b1;
          end
          flags |= FlAddrSeen;
        end
        FnLoad: if (c.full) begin
          if (half) begin
            image_mem[mem_ptr] = {byte_lo, c.data[7:0]};
            half = 1'b0;
            mem_ptr++;
            flags |= FlMemMoved;
          end else begin
            half = 1'b1;
            byte_lo = c.data[7:0];
          end
          r.tk = 1'b1;
        end
        default: ;
      endcase
    end else if (c.kind == KindTick) begin
      if (tick_cnt < TickMax) tick_cnt++;
    end
    r.fl = flags;
    r.run = (prog_st == StRunning);
    return r;
  endfunction

  // Offers one beat, holding it until taken; the expectation is queued on acceptance.
  task automatic offer(cmd_t c, logic given = 1'b0, reply_t want = '0);
    reply_t r;
    while (!calm && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= c.kind;
    func_code_i <= c.fc;
    chan_data_i <= c.data;
    chan_full_i <= c.full;
    do @(posedge clk_i); while (!in_ready_o);
    r = coupler_step(c);
    replies_due.push_back(given ? want : r);
  endtask

  // Function codes carry random equipment bits, which the coupler ignores.
  task automatic func(logic [8:0] code);
    offer('{KindFunc, {3'($urandom_range(7)), code}, 12'($urandom), 1'($urandom)});
  endtask

  task automatic io(logic [11:0] d, logic f);
    offer('{KindIo, 12'($urandom), d, f});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_idle_interval(logic [19:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    idle_ticks = v;
  endtask

  // Loads sixteen words at address zero, summing to a fingerprint most of the
  // time, then starts the program.
  task automatic load_and_start();
    logic [15:0] words [16];
    logic [15:0] target;
    logic [15:0] acc;
    int pick;
    acc = '0;
    pick = $urandom_range(4);
    case (pick)
      0: target = SumImageA;
      1: target = SumImageB;
      2: target = SumImageC;
      3: target = SumImageD;
      default: target = 16'($urandom);
    endcase
    for (int i = 0; i < 15; i++) begin
      words[i] = 16'($urandom);
      acc += words[i];
    end
    words[15] = target - acc;
    func(FnMaster);
    func(FnWrAddrHi);
    io(12'($urandom) & 12'hF00, 1'b1);
    func(FnWrAddrLo);
    io(12'($urandom) & 12'hF00, 1'b1);
    func(FnLoad);
    for (int i = 0; i < 16; i++) begin
      io({4'($urandom), words[i][15:8]}, 1'b1);
      if ($urandom_range(9) == 0) io(12'($urandom), 1'b0);
      io({4'($urandom), words[i][7:0]}, 1'b1);
    end
    func(FnStart);
    if ($urandom_range(1)) func(FnStart);
  endtask

  task automatic random_seq();
    int n;
    n = $urandom_range(99);
    if (n < 12) begin
      load_and_start();
    end else if (n < 27) begin
      func(FnWrStatus);
      repeat ($urandom_range(1, 3)) io(12'($urandom), 1'($urandom_range(3) != 0));
      func(FnRdOrder);
      io(12'($urandom), 1'($urandom));
    end else if (n < 40) begin
      func(FnWrAddrHi);
      io(12'($urandom), 1'b1);
      func(FnWrAddrLo);
      io($urandom_range(1) ? 12'($urandom_range(20)) : 12'($urandom), 1'b1);
      func(FnDump);
      repeat ($urandom_range(1, 6)) io(12'($urandom), 1'($urandom));
    end else if (n < 55) begin
      case ($urandom_range(4))
        0: func(FnRdStatus);
        1: func(FnRdCoupl);
        2: func(FnRdAddrHi);
        3: func(FnRdAddrLo);
        default: func(FnClear);
      endcase
      io(12'($urandom), 1'($urandom));
    end else if (n < 70) begin
      repeat ($urandom_range(1, 12)) offer('{KindTick, 12'($urandom), 12'($urandom), 1'($urandom)});
      func(FnRdCoupl);
      io(12'($urandom), 1'($urandom));
    end else begin
      offer('{2'($urandom), 12'($urandom), 12'($urandom), 1'($urandom)});
    end
  endtask

  // Directed rows. Only the first few, straight after reset, carry a fixed reply.
  row_t plan [] = '{
    '{'{2'd3, 12'o7777, 12'hFFF, 1'b1}, 1'b1, '{FsDeclined, 12'h0, 1'b0, 1'b0, EvNone, 11'h0, 1'b0}},
    '{'{KindTick, 12'h0, 12'h0, 1'b0}, 1'b1, '{FsDeclined, 12'h0, 1'b0, 1'b0, EvNone, 11'h0, 1'b0}},
    '{'{KindIo, 12'hFFF, 12'hFFF, 1'b1}, 1'b1, '{FsDeclined, 12'h0, 1'b0, 1'b0, EvNone, 11'h0, 1'b0}},
    '{'{KindFunc, {3'o0, FnDataA}, 12'h0, 1'b0}, 1'b1, '{FsDeclined, 12'h0, 1'b0, 1'b0, EvNone, 11'h0, 1'b0}},
    '{'{KindFunc, 12'o7777, 12'h0, 1'b0}, 1'b1, '{FsDeclined, 12'h0, 1'b0, 1'b0, EvNone, 11'h0, 1'b0}},
    '{'{KindFunc, {3'o7, FnRdCoupl}, 12'h0, 1'b0}, 1'b1, '{FsAccepted, 12'h0, 1'b0, 1'b0, EvNone, 11'h0, 1'b0}},
    '{'{KindIo, 12'h0, 12'h0, 1'b0}, 1'b1, '{FsDeclined, 12'h0, 1'b1, 1'b0, EvNone, FlCouplRead, 1'b0}},
    '{'{KindFunc, {3'o0, FnClear}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnWrStatus}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'hFFF, 1'b1}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'h200, 1'b1}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnRdOrder}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnRdStatus}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnStart}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnWrAddrHi}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'hFFF, 1'b1}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnWrAddrLo}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'h0FF, 1'b1}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnRdAddrHi}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnRdAddrLo}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnLoad}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'hEAB, 1'b1}, 1'b0, '0},
    '{'{KindIo, 12'h0, 12'h1CD, 1'b1}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnMaster}, 12'h0, 1'b0}, 1'b0, '0},
    '{'{KindFunc, {3'o0, FnDataB}, 12'h0, 1'b0}, 1'b0, '0}
  };

  // Result side: checks every beat taken, with random stalls and one long hold-off.
  initial begin
    reply_t got;
    reply_t want;
    int beats;
    int hold;
    beats = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{func_status_o, read_data_o, read_valid_o, data_taken_o,
                event_res_o, coupler_flags_o, hcp_running_o};
        beats++;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (beats == 500 && !hold_done) begin
        // Long back-pressure so the block fills up and stops taking commands.
        hold_done = 1'b1;
        hold = 400;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // Watchdog over cycles without any accepted beat; it covers the store sweep after reset.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [19:0] intervals [4];
    intervals = '{20'd1, 20'hFFFFF, 20'd5, IdleReset};
    idle_ticks = IdleReset;
    flags = '0;
    status_word = '0;
    order_word = '0;
    mem_ptr = '0;
    addr_hi = '0;
    byte_lo = '0;
    half = 1'b0;
    prog_st = StNotInit;
    act_fn = FnNothing;
    tick_cnt = '0;
    foreach (image_mem[i]) image_mem[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run under the reset value of the idle interval.
    foreach (plan[i]) offer(plan[i].cmd, plan[i].given, plan[i].reply);
    drain();

    // Each phase changes the idle interval while the block is quiet; the
    // third phase runs without any idling on either side.
    for (int p = 0; p < 4; p++) begin
      set_idle_interval(intervals[p]);
      calm = (p == 2);
      for (int k = 0; k < 50; k++) random_seq();
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
